[hdl/jkvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkvs_pkg
// Shared types, register map, status codes and character constants for the
// JSON key/value scanner.
// ----------------------------------------------------------------------------
package jkvs_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  // key storage: five 64-bit registers hold up to 37 characters
  localparam int KEY_REGS  = 5;
  localparam int KEY_CHARS = 37;

  typedef logic [KEY_CHARS-1:0][7:0] key_chars_t;

  // register indexes (byte address / 8)
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_THIRD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_FOURTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_MODE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = 3'd7;

  // value modes
  localparam logic [1:0] MODE_STRING   = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_UNSIGNED = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;

  // reset value of the string capacity
  localparam logic [8:0] CAPACITY_RESET = 9'd64;

  // characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

[hdl/jkvs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkvs_cell
// One stage of the recent-byte window: holds a byte, passes it on to the
// next older stage and compares it with the character expected there.
// ----------------------------------------------------------------------------
module jkvs_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [7:0] byte_in,
  input  logic [7:0] expected,
  input  logic       care,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] byte_r;

  // shift in the neighbor's byte, cleared at the end of a document
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else if (shift_en) begin
      byte_r <= clear ? 8'h00 : byte_in;
    end
  end

  assign byte_out = byte_r;
  // positions outside the pattern always agree
  assign hit      = !care || (byte_r == expected);

endmodule

[hdl/jkvs_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkvs_window
// Row of window cells holding the latest document bytes; decides whether the
// newest byte closes the quoted key.
// ----------------------------------------------------------------------------
module jkvs_window #(
  parameter int KEY_MAX_LEN = 37
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic                clear,
  input  logic [7:0]          text_byte,
  input  jkvs_pkg::key_chars_t key_chars,
  input  logic [5:0]          key_length,
  output logic                match
);
  import jkvs_pkg::*;

  localparam int CELLS = KEY_MAX_LEN + 1;

  logic [CELLS-1:0][7:0] chain;
  logic [CELLS-1:0]      hits;
  logic                  key_ok;
  logic [6:0]            quote_pos;

  assign key_ok    = (key_length <= 6'(KEY_MAX_LEN));
  assign quote_pos = {1'b0, key_length} + 7'd1;

  // cell k holds the byte k+1 places older than the newest one
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [5:0] key_idx;
    logic [7:0] expected;
    logic       care;
    logic [7:0] byte_in;

    // key character that lines up with this position for the current length
    assign key_idx = key_length - 6'(k + 1);
    always_comb begin
      if (7'(k + 1) <= {1'b0, key_length}) begin
        expected = (key_idx < 6'(KEY_CHARS)) ? key_chars[key_idx] : 8'h00;
      end else begin
        expected = CH_QUOTE;
      end
    end
    assign care = (7'(k + 1) <= quote_pos);

    if (k == 0) begin : g_head
      assign byte_in = text_byte;
    end else begin : g_link
      assign byte_in = chain[k-1];
    end

    jkvs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clear    (clear),
      .byte_in  (byte_in),
      .expected (expected),
      .care     (care),
      .byte_out (chain[k]),
      .hit      (hits[k])
    );
  end

  // closing quote arrives now, every cell in the pattern agrees
  assign match = key_ok && (text_byte == CH_QUOTE) && (&hits);

endmodule

[hdl/json_key_value_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_value_scanner
// Streams a JSON document byte by byte, finds the first "key": and extracts
// its value as a string, a signed integer or an unsigned 32-bit integer.
// ----------------------------------------------------------------------------
// The scanner takes one document byte per clock cycle and gives at most one
// result word per byte, in the cycle after the byte is taken. The key search
// runs over a row of KEY_MAX_LEN+1 window cells that all compare at once, and
// the single output register sets the rate: a new byte is taken in the same
// cycle that a waiting result leaves, so the stream runs at one byte per
// cycle while the output side keeps up. A result word carries either one
// string character, the final status with the number, or both when the last
// byte of the document also holds a character. After the status word the
// rest of the document is consumed silently up to in_last_byte, and all scan
// state returns to its reset value there. No clearing pass follows reset.
// The key, length, mode and capacity registers sit at byte addresses 8*i.
// ----------------------------------------------------------------------------
module json_key_value_scanner #(
  parameter int KEY_MAX_LEN = 37,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_last_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_char_valid,
  output logic [7:0]                      out_char_byte,
  output logic                            out_done_res,
  output logic [1:0]                      out_status,
  output logic [31:0]                     out_number,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jkvs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jkvs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jkvs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import jkvs_pkg::*;

  localparam int ACC_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic [ACC_W:0]   VAL_ONE  = (ACC_W + 1)'(1) << VALUE_WIDTH;
  localparam logic [ACC_W-1:0] VAL_MASK = ACC_W'(VAL_ONE - (ACC_W + 1)'(1));
  localparam logic [ACC_W-1:0] U32_MASK = ACC_W'(32'hFFFF_FFFF);

  // scan phases
  localparam logic [2:0] PH_SEARCH      = 3'd0;
  localparam logic [2:0] PH_AFTER_KEY   = 3'd1;
  localparam logic [2:0] PH_AFTER_COLON = 3'd2;
  localparam logic [2:0] PH_STRING      = 3'd3;
  localparam logic [2:0] PH_DIGITS      = 3'd4;
  localparam logic [2:0] PH_DONE        = 3'd5;

  // configuration registers
  logic [CFG_DATA_W-1:0] key_regs_r [KEY_REGS];
  logic [5:0]            key_length_r;
  logic [1:0]            value_mode_r;
  logic [8:0]            capacity_r;

  // scan state
  logic [2:0]       phase_r, phase_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic             dseen_r, dseen_nxt;
  logic [8:0]       chars_r, chars_nxt;

  // output register
  logic        out_valid_r;
  logic        out_char_valid_r;
  logic [7:0]  out_char_byte_r;
  logic        out_done_res_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_number_r;

  logic             accept;
  logic             match;
  logic             cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  key_chars_t       key_chars;
  logic [ACC_W-1:0] acc_digit;
  logic [ACC_W-1:0] acc_signed;
  logic [31:0]      final_num;
  logic             done, cvalid, num_ok, emit;
  logic [1:0]       st;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_regs_r[i] <= '0;
      end
      key_length_r <= '0;
      value_mode_r <= MODE_STRING;
      capacity_r   <= CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_KEY_LOW:    key_regs_r[0] <= pwdata;
        REG_KEY_SECOND: key_regs_r[1] <= pwdata;
        REG_KEY_THIRD:  key_regs_r[2] <= pwdata;
        REG_KEY_FOURTH: key_regs_r[3] <= pwdata;
        REG_KEY_HIGH:   key_regs_r[4] <= pwdata;
        REG_KEY_LENGTH: key_length_r  <= pwdata[5:0];
        REG_VALUE_MODE: value_mode_r  <= pwdata[1:0];
        REG_CAPACITY:   capacity_r    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:    prdata = key_regs_r[0];
      REG_KEY_SECOND: prdata = key_regs_r[1];
      REG_KEY_THIRD:  prdata = key_regs_r[2];
      REG_KEY_FOURTH: prdata = key_regs_r[3];
      REG_KEY_HIGH:   prdata = key_regs_r[4];
      REG_KEY_LENGTH: prdata = CFG_DATA_W'(key_length_r);
      REG_VALUE_MODE: prdata = CFG_DATA_W'(value_mode_r);
      REG_CAPACITY:   prdata = CFG_DATA_W'(capacity_r);
      default:        prdata = '0;
    endcase
  end

  // key characters in order, upper bytes of the last register dropped
  always_comb begin
    for (int i = 0; i < KEY_CHARS; i++) begin
      key_chars[i] = key_regs_r[i / 8][(i % 8) * 8 +: 8];
    end
  end

  // ---------------- handshake ----------------
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // ---------------- key window ----------------
  jkvs_window #(
    .KEY_MAX_LEN (KEY_MAX_LEN)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (accept),
    .clear      (in_last_byte),
    .text_byte  (in_text_byte),
    .key_chars  (key_chars),
    .key_length (key_length_r),
    .match      (match)
  );

  // ---------------- value extraction ----------------
  // times ten plus digit, wrapped to the mode's width
  always_comb begin
    acc_digit = (acc_r << 3) + (acc_r << 1) + ACC_W'(in_text_byte[3:0]);
    acc_digit = acc_digit & ((value_mode_r == MODE_SIGNED) ? VAL_MASK : U32_MASK);
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    dseen_nxt = dseen_r;
    chars_nxt = chars_r;
    done      = 1'b0;
    cvalid    = 1'b0;
    num_ok    = 1'b0;
    st        = ST_OK;

    unique case (phase_r)
      PH_SEARCH: begin
        if (match) phase_nxt = PH_AFTER_KEY;
      end
      PH_AFTER_KEY: begin
        if (!is_ws(in_text_byte)) begin
          if (in_text_byte == CH_COLON) begin
            phase_nxt = PH_AFTER_COLON;
          end else begin
            phase_nxt = match ? PH_AFTER_KEY : PH_SEARCH;
          end
        end
      end
      PH_AFTER_COLON: begin
        if (!is_ws(in_text_byte)) begin
          unique case (value_mode_r)
            MODE_STRING: begin
              if (in_text_byte == CH_QUOTE && capacity_r != 9'd0) begin
                phase_nxt = PH_STRING;
              end else begin
                done = 1'b1;
                st   = ST_BAD;
              end
            end
            MODE_SIGNED: begin
              if (in_text_byte == CH_MINUS || in_text_byte == CH_PLUS) begin
                neg_nxt   = (in_text_byte == CH_MINUS);
                phase_nxt = PH_DIGITS;
              end else if (is_digit(in_text_byte)) begin
                acc_nxt   = acc_digit;
                dseen_nxt = 1'b1;
                phase_nxt = PH_DIGITS;
              end else begin
                done = 1'b1;
                st   = ST_BAD;
              end
            end
            MODE_UNSIGNED: begin
              if (in_text_byte == CH_PLUS) begin
                phase_nxt = PH_DIGITS;
              end else if (is_digit(in_text_byte)) begin
                acc_nxt   = acc_digit;
                dseen_nxt = 1'b1;
                phase_nxt = PH_DIGITS;
              end else begin
                done = 1'b1;
                st   = ST_BAD;
              end
            end
            default: begin
              done = 1'b1;
              st   = ST_BAD;
            end
          endcase
        end
      end
      PH_STRING: begin
        if (in_text_byte == CH_QUOTE) begin
          done = 1'b1;
          st   = ST_OK;
        end else if ({1'b0, chars_r} + 10'd1 < {1'b0, capacity_r}) begin
          cvalid    = 1'b1;
          chars_nxt = chars_r + 9'd1;
        end else begin
          done = 1'b1;
          st   = ST_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_digit(in_text_byte)) begin
          acc_nxt   = acc_digit;
          dseen_nxt = 1'b1;
        end else begin
          done = 1'b1;
          if (dseen_r) begin
            st     = ST_OK;
            num_ok = 1'b1;
          end else begin
            st = ST_BAD;
          end
        end
      end
      default: ;
    endcase

    if (done) phase_nxt = PH_DONE;

    // end of document before a status was given
    if (in_last_byte && phase_nxt != PH_DONE) begin
      done = 1'b1;
      if (phase_nxt == PH_SEARCH || phase_nxt == PH_AFTER_KEY) begin
        st = ST_NOT_FOUND;
      end else if (phase_nxt == PH_DIGITS && dseen_nxt) begin
        st     = ST_OK;
        num_ok = 1'b1;
      end else begin
        st = ST_BAD;
      end
    end
  end

  // final number, negated in signed mode
  always_comb begin
    acc_signed = neg_nxt ? (ACC_W'(0) - acc_nxt) : acc_nxt;
    if (value_mode_r == MODE_SIGNED) begin
      final_num = 32'(acc_signed & VAL_MASK);
    end else begin
      final_num = 32'(acc_nxt);
    end
  end

  assign emit = cvalid || done;

  // scan state, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      dseen_r <= 1'b0;
      chars_r <= '0;
    end else if (accept) begin
      if (in_last_byte) begin
        phase_r <= PH_SEARCH;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        dseen_r <= 1'b0;
        chars_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        dseen_r <= dseen_nxt;
        chars_r <= chars_nxt;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_char_valid_r <= cvalid;
      out_char_byte_r  <= cvalid ? in_text_byte : 8'h00;
      out_done_res_r   <= done;
      out_status_r     <= done ? st : ST_OK;
      out_number_r     <= num_ok ? final_num : 32'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = out_char_valid_r;
  assign out_char_byte  = out_char_byte_r;
  assign out_done_res   = out_done_res_r;
  assign out_status     = out_status_r;
  assign out_number     = out_number_r;

  // ---------------- assertions ----------------
  // every result word carries a character or a status
  a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_valid_r || out_done_res_r))
    else $error("result word with neither character nor status");

  // status and number stay zero until the document is settled
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_res_r) |-> (out_status_r == ST_OK && out_number_r == 32'd0))
    else $error("status or number set on a character-only word");

  // the last byte returns the scan to the key search
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (phase_r == PH_SEARCH && !dseen_r && chars_r == 9'd0))
    else $error("scan state not cleared after the last byte");

  // characters only come out of a quoted string value
  a_char_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cvalid) |-> (phase_r == PH_STRING))
    else $error("character emitted outside a string value");

  // a digit was seen only while parsing or after the number settled
  a_digit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    dseen_r |-> (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("digit flag set outside number parsing");

endmodule
